@@ src/mlp2_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp2_pkg
// Shared types, constants and the sigmoid lookup table for the two-layer
// perceptron inference block.
// ----------------------------------------------------------------------------
package mlp2_pkg;

   localparam int MAX_INPUTS      = 16;
   localparam int MAX_HIDDEN      = 16;
   localparam int MAX_OUTPUTS     = 8;
   localparam int SIGMOID_ENTRIES = 256;

   localparam int PARAM_WORDS = 512;
   localparam int PARAM_AW    = $clog2(PARAM_WORDS);
   localparam int BIN_WIDTH   = 65536 / SIGMOID_ENTRIES;
   localparam int LUT_AW      = $clog2(SIGMOID_ENTRIES);

   // Parameter memory layout.
   localparam int BH_BASE  = MAX_INPUTS * MAX_HIDDEN;
   localparam int WHO_BASE = BH_BASE + MAX_HIDDEN;
   localparam int BO_BASE  = WHO_BASE + MAX_HIDDEN * MAX_OUTPUTS;

   localparam int CNT_W  = 5;
   localparam int IDX_W  = $clog2(MAX_INPUTS > MAX_HIDDEN ? MAX_INPUTS : MAX_HIDDEN);
   localparam int NEUR_W = $clog2(MAX_HIDDEN > MAX_OUTPUTS ? MAX_HIDDEN : MAX_OUTPUTS);
   localparam int ACC_W  = 24;

   // Item kinds on the request channel.
   localparam logic OP_PARAM = 1'b0;
   localparam logic OP_INPUT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_IN_COUNT     = 2'd0;
   localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
   localparam logic [1:0] REG_OUT_COUNT    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HID_RUN,
      ST_OUT_WAIT,
      ST_OUT_RUN
   } state_type;

   typedef enum logic {
      LAYER_HIDDEN,
      LAYER_OUTPUT
   } layer_type;

   typedef struct packed {
      logic [CNT_W-1:0] in_count;
      logic [CNT_W-1:0] hidden_count;
      logic [3:0]       out_count;
   } csr_type;

   // Tag that travels down the multiply-accumulate pipeline with each term.
   typedef struct packed {
      logic              valid;
      layer_type         layer;
      logic              first;
      logic              bias;
      logic              run_end;
      logic [NEUR_W-1:0] neuron;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic [PARAM_AW-1:0] addr;
      logic [IDX_W-1:0]  idx;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic rsp_busy;
   } status_type;

   typedef logic [15:0] sig_lut_type [SIGMOID_ENTRIES];

   // Entry k holds round(65535 * sigmoid(c)), c being the center of bin k.
   function automatic sig_lut_type build_sig_lut();
      sig_lut_type lut;
      real c;
      real e;
      real p;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         c = real'(2 * k * BIN_WIDTH - 65536 + BIN_WIDTH - 1) / 8192.0;
         e = $exp(c < 0.0 ? c : -c);
         p = (c < 0.0) ? e : 1.0;
         lut[k] = 16'($rtoi(65535.0 * p * ((1.0 + e) ** (-1.0)) + 0.5));
      end
      return lut;
   endfunction

   localparam sig_lut_type SIG_LUT = build_sig_lut();

   // A count of zero acts as one; larger values saturate at the maximum.
   function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v, int mx);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (int'(v) > mx) begin
         r = CNT_W'(mx);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ src/mlp2_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp2_csr
// Register file for the layer sizes, written and read over a simple
// peripheral bus.
// ----------------------------------------------------------------------------
module mlp2_csr import mlp2_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output csr_type     csr
);

   logic [CNT_W-1:0] in_count_ff, in_count_in;
   logic [CNT_W-1:0] hidden_count_ff, hidden_count_in;
   logic [3:0]       out_count_ff, out_count_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      in_count_in     = in_count_ff;
      hidden_count_in = hidden_count_ff;
      out_count_in    = out_count_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_IN_COUNT:     in_count_in     = csr_pwdata[CNT_W-1:0];
            REG_HIDDEN_COUNT: hidden_count_in = csr_pwdata[CNT_W-1:0];
            REG_OUT_COUNT:    out_count_in    = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff     <= CNT_W'(2);
         hidden_count_ff <= CNT_W'(2);
         out_count_ff    <= 4'd1;
      end else begin
         in_count_ff     <= in_count_in;
         hidden_count_ff <= hidden_count_in;
         out_count_ff    <= out_count_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_IN_COUNT:     csr_prdata = 32'(in_count_ff);
         REG_HIDDEN_COUNT: csr_prdata = 32'(hidden_count_ff);
         REG_OUT_COUNT:    csr_prdata = 32'(out_count_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr.in_count     = in_count_ff;
   assign csr.hidden_count = hidden_count_ff;
   assign csr.out_count    = out_count_ff;

endmodule

@@ src/mlp2_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp2_ctrl
// Sequencer that walks the weights of both layers, issuing commands to the
// datapath, one multiply-accumulate term per cycle outside ST_OUT_WAIT.
// ----------------------------------------------------------------------------
module mlp2_ctrl import mlp2_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr,
   input  logic       req_tvalid,
   input  logic       req_op,
   input  logic       req_final,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] term_ff, term_in;
   logic [CNT_W-1:0] neuron_ff, neuron_in;
   logic [CNT_W-1:0] ni, nh, no;
   logic             bias_cycle;

   assign ni = clamp_count(csr.in_count, MAX_INPUTS);
   assign nh = clamp_count(csr.hidden_count, MAX_HIDDEN);
   assign no = clamp_count(CNT_W'(csr.out_count), MAX_OUTPUTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         term_ff   <= '0;
         neuron_ff <= '0;
      end else begin
         state_ff  <= state_in;
         term_ff   <= term_in;
         neuron_ff <= neuron_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      term_in    = term_ff;
      neuron_in  = neuron_ff;
      req_tready = 1'b0;
      bias_cycle = 1'b0;
      cmd        = '0;
      cmd.tag.neuron = neuron_ff[NEUR_W-1:0];
      cmd.idx        = term_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_op == OP_INPUT && req_final) begin
               state_in  = ST_HID_RUN;
               term_in   = '0;
               neuron_in = '0;
            end
         end

         ST_HID_RUN: begin
            bias_cycle        = (term_ff == ni);
            cmd.tag.valid     = 1'b1;
            cmd.tag.layer     = LAYER_HIDDEN;
            cmd.tag.first     = (term_ff == '0);
            cmd.tag.bias      = bias_cycle;
            cmd.addr = bias_cycle ? PARAM_AW'(BH_BASE + int'(neuron_ff))
                                  : PARAM_AW'(int'(term_ff) * MAX_HIDDEN + int'(neuron_ff));
            if (bias_cycle) begin
               term_in = '0;
               if (neuron_ff == nh - CNT_W'(1)) begin
                  state_in  = ST_OUT_WAIT;
                  neuron_in = '0;
               end else begin
                  neuron_in = neuron_ff + CNT_W'(1);
               end
            end else begin
               term_in = term_ff + CNT_W'(1);
            end
         end

         // The hidden layer must be fully written back and the result
         // register free before an output neuron starts.
         ST_OUT_WAIT: begin
            if (!status.pipe_busy && !status.rsp_busy) begin
               state_in = ST_OUT_RUN;
               term_in  = '0;
            end
         end

         ST_OUT_RUN: begin
            bias_cycle        = (term_ff == nh);
            cmd.tag.valid     = 1'b1;
            cmd.tag.layer     = LAYER_OUTPUT;
            cmd.tag.first     = (term_ff == '0);
            cmd.tag.bias      = bias_cycle;
            cmd.tag.run_end   = (neuron_ff == no - CNT_W'(1));
            cmd.addr = bias_cycle ? PARAM_AW'(BO_BASE + int'(neuron_ff))
                                  : PARAM_AW'(WHO_BASE + int'(term_ff) * MAX_OUTPUTS
                                              + int'(neuron_ff));
            if (bias_cycle) begin
               term_in = '0;
               if (neuron_ff == no - CNT_W'(1)) begin
                  state_in  = ST_IDLE;
                  neuron_in = '0;
               end else begin
                  state_in  = ST_OUT_WAIT;
                  neuron_in = neuron_ff + CNT_W'(1);
               end
            end else begin
               term_in = term_ff + CNT_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_out_run_rsp_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT_RUN |-> !status.rsp_busy)
      else $error("output neuron issued while result register occupied");

   a_out_start_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT_WAIT && state_in == ST_OUT_RUN |-> !status.pipe_busy)
      else $error("output layer started with pipeline busy");
`endif

endmodule

@@ src/mlp2_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp2_datapath
// Parameter memory, input and hidden buffers, and the pipelined
// multiply-accumulate unit with saturation and sigmoid lookup.
// ----------------------------------------------------------------------------
module mlp2_datapath import mlp2_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                req_op,
   input  logic [8:0]          req_slot,
   input  logic signed [15:0]  req_value,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [2:0]          rsp_neuron,
   output logic [15:0]         rsp_activation,
   output logic                rsp_run_end
);

   logic [15:0]        pmem [PARAM_WORDS];
   logic signed [15:0] in_buf_ff [MAX_INPUTS];
   logic [15:0]        hid_buf_ff [MAX_HIDDEN];

   tag_type            s1_ff, s2_ff, s3_ff;
   tag_type            s3_in;
   logic signed [15:0] rd_ff;
   logic signed [16:0] x_ff;
   logic signed [32:0] prod_ff;
   logic signed [15:0] bias_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] term;
   logic signed [15:0] z_sat;
   logic [15:0]        z_off;
   logic [15:0]        act;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_neuron_ff;
   logic [15:0]        rsp_act_ff;
   logic               rsp_run_end_ff;

   // Parameter memory: written by parameter beats, read by the sequencer.
   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_PARAM) begin
         pmem[req_slot] <= req_value;
      end
      if (cmd.tag.valid) begin
         rd_ff <= pmem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_INPUT && int'(req_slot) < MAX_INPUTS) begin
         in_buf_ff[req_slot[IDX_W-1:0]] <= req_value;
      end
   end

   // Stage 1: operand fetch.
   always_ff @(posedge clock) begin
      if (cmd.tag.valid) begin
         if (cmd.tag.layer == LAYER_OUTPUT) begin
            x_ff <= $signed({1'b0, hid_buf_ff[cmd.idx]});
         end else begin
            x_ff <= 17'(in_buf_ff[cmd.idx]);
         end
      end
   end

   // Stage 2: multiply.
   always_ff @(posedge clock) begin
      prod_ff <= rd_ff * x_ff;
      bias_ff <= rd_ff;
   end

   // Stage 3: floor-shifted product or bias into the accumulator.
   always_comb begin
      if (s2_ff.bias) begin
         term = ACC_W'(bias_ff);
      end else if (s2_ff.layer == LAYER_OUTPUT) begin
         term = ACC_W'($signed(prod_ff[32:16]));
      end else begin
         term = ACC_W'($signed(prod_ff[32:12]));
      end
      acc_in = (s2_ff.first ? ACC_W'(0) : acc_ff) + term;
   end

   always_ff @(posedge clock) begin
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // Only the bias term of a neuron carries a finished sum into stage 4.
   always_comb begin
      s3_in       = s2_ff;
      s3_in.valid = s2_ff.valid & s2_ff.bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= cmd.tag;
         s2_ff <= s1_ff;
         s3_ff <= s3_in;
      end
   end

   // Stage 4: saturate, look up the sigmoid and write back.
   always_comb begin
      if (acc_ff > ACC_W'(32767)) begin
         z_sat = 16'sd32767;
      end else if (acc_ff < -ACC_W'(32768)) begin
         z_sat = -16'sd32768;
      end else begin
         z_sat = acc_ff[15:0];
      end
      z_off = {~z_sat[15], z_sat[14:0]};
      act   = SIG_LUT[z_off[15 -: LUT_AW]];
   end

   always_ff @(posedge clock) begin
      if (s3_ff.valid && s3_ff.layer == LAYER_HIDDEN) begin
         hid_buf_ff[s3_ff.neuron[IDX_W-1:0]] <= act;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s3_ff.valid && s3_ff.layer == LAYER_OUTPUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ff.valid && s3_ff.layer == LAYER_OUTPUT) begin
         rsp_neuron_ff  <= s3_ff.neuron[2:0];
         rsp_act_ff     <= act;
         rsp_run_end_ff <= s3_ff.run_end;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_neuron     = rsp_neuron_ff;
   assign rsp_activation = rsp_act_ff;
   assign rsp_run_end    = rsp_run_end_ff;

   assign status.pipe_busy = s1_ff.valid | s2_ff.valid | s3_ff.valid;
   assign status.rsp_busy  = rsp_valid_ff;

`ifndef SYNTH
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s3_ff.valid && s3_ff.layer == LAYER_OUTPUT |-> !rsp_valid_ff)
      else $error("output result would overwrite a pending beat");

   a_hidden_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.tag.valid && cmd.tag.layer == LAYER_OUTPUT |->
         !(s1_ff.valid && s1_ff.layer == LAYER_HIDDEN) &&
         !(s2_ff.valid && s2_ff.layer == LAYER_HIDDEN) &&
         !(s3_ff.valid && s3_ff.layer == LAYER_HIDDEN))
      else $error("output layer read hidden values still in flight");
`endif

endmodule

@@ src/mlp_two_layer_sigmoid_inference.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_two_layer_sigmoid_inference
// Fixed-point forward pass of an input-hidden-output perceptron with sigmoid
// activations on both layers.
// ----------------------------------------------------------------------------
// Usage:
// The req stream carries two kinds of beat (tuser): a parameter beat writes
// one weight or bias word at address slot; an input beat stores one element
// at position slot. An input beat with tlast set starts evaluation of the
// sample. The rsp stream then delivers out_count beats (zero counts as one,
// at most 8), one per output neuron, with tlast on the last. Layer sizes are
// set through the csr port. Beats are accepted whenever the block is idle.
// After a final beat the single shared multiply-accumulate unit takes one
// term per cycle, except while it waits for the pipeline to drain before
// each output neuron: first all terms of the hidden layer, then the terms
// of each output neuron in turn. New req beats are taken once the last
// output neuron has been issued, while its result is still in the pipeline.
// When rsp stalls, the next output neuron waits until the result register
// is free; no result is dropped. Reset clears the control state and sets
// the counts to 2, 2 and 1; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module mlp_two_layer_sigmoid_inference import mlp2_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // slot[8:0], value[24:9], zero pad
   input  logic        req_tuser,   // op
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // neuron[2:0], activation[18:3], zero pad
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   csr_type     csr;
   cmd_type     cmd;
   status_type  status;
   logic        req_fire;
   logic [2:0]  rsp_neuron;
   logic [15:0] rsp_activation;

   assign req_fire = req_tvalid & req_tready;

   mlp2_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr         (csr)
   );

   mlp2_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_final  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mlp2_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_op         (req_tuser),
      .req_slot       (req_tdata[8:0]),
      .req_value      (req_tdata[24:9]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_neuron     (rsp_neuron),
      .rsp_activation (rsp_activation),
      .rsp_run_end    (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, rsp_activation, rsp_neuron};

endmodule
